// File: rtl/sm3_pkg.sv
package sm3_pkg;

   localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
   localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [1:0] MODE_ABSORB = 2'd0;
   localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   localparam int DIGEST_WORDS = 8;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] chain_type;

   localparam chain_type SM3_IV = '{
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

   // datapath byte source select
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN
   } src_type;

   // controller to datapath
   typedef struct packed {
      logic       write_byte;   // write one byte into the block buffer
      src_type    src;
      logic [7:0] data;
      logic       count_len;    // add 8 to the bit length
      logic       comp_start;   // load work regs from the chain, clear round count
      logic       round_en;     // run one round
      logic       comp_done;    // fold work regs into chain
      logic       reinit;       // IV, zero counts
      logic [2:0] out_index;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic [5:0] round;
   } status_type;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// File: rtl/sm3_stream_if.sv
interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   modport source (output valid, mode, data_byte, input ready);
   modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sm3_datapath.sv
module sm3_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sm3_pkg::cmd_type     cmd,
   output sm3_pkg::status_type  status,
   output sm3_pkg::word_type    out_word
);
   import sm3_pkg::*;

   word_type    window_ff [16];
   word_type    work_ff [8];
   chain_type   chain_ff;
   logic [5:0]  fill_ff;
   logic [63:0] len_ff;
   logic [5:0]  round_ff;
   logic [7:0]  wr_byte;

   // byte source
   always_comb begin
      case (cmd.src)
         SRC_DATA: wr_byte = cmd.data;
         SRC_PAD:  wr_byte = PAD_BYTE;
         SRC_ZERO: wr_byte = 8'h00;
         SRC_LEN:  wr_byte = len_ff[8*(7-fill_ff[2:0]) +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   // round logic
   word_type wj, wpj, tconst, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
   always_comb begin
      wj = window_ff[round_ff[3:0]];
      wpj = wj ^ window_ff[round_ff[3:0] + 4'd4];
      tconst = (round_ff < 6'd16) ? TJ_LOW : TJ_HIGH;
      a12 = rotl(work_ff[0], 5'd12);
      ss1 = rotl(a12 + work_ff[4] + rotl(tconst, round_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         gg = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ff = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2]) |
              (work_ff[1] & work_ff[2]);
         gg = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ff + work_ff[3] + ss2 + wpj;
      tt2 = gg + work_ff[7] + ss1 + wj;
      wn = perm1(wj ^ window_ff[round_ff[3:0] + 4'd7] ^
                 rotl(window_ff[round_ff[3:0] + 4'd13], 5'd15)) ^
           rotl(window_ff[round_ff[3:0] + 4'd3], 5'd7) ^
           window_ff[round_ff[3:0] + 4'd10];
   end

   // expansion window: bytes land big-endian in place, rounds slide it
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         window_ff[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] <= wr_byte;
      end else if (cmd.round_en) begin
         window_ff[round_ff[3:0]] <= wn;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (cmd.comp_start) begin
         for (int k = 0; k < 8; k++) begin
            work_ff[k] <= chain_ff[k];
         end
      end else if (cmd.round_en) begin
         work_ff[0] <= tt1;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= rotl(work_ff[1], 5'd9);
         work_ff[3] <= work_ff[2];
         work_ff[4] <= perm0(tt2);
         work_ff[5] <= work_ff[4];
         work_ff[6] <= rotl(work_ff[5], 5'd19);
         work_ff[7] <= work_ff[6];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         chain_ff <= SM3_IV;
         fill_ff <= '0;
         len_ff <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.write_byte) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count_len) begin
            len_ff <= len_ff + 64'd8;
         end
         if (cmd.comp_start) begin
            round_ff <= '0;
         end else if (cmd.round_en) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.comp_done) begin
            for (int k = 0; k < 8; k++) begin
               chain_ff[k] <= chain_ff[k] ^ work_ff[k];
            end
         end
      end
   end

   assign status.fill = fill_ff;
   assign status.round = round_ff;
   assign out_word = chain_ff[cmd.out_index];
endmodule

// File: rtl/sm3_control.sv
module sm3_control (
   input  logic                clock,
   input  logic                reset,
   sm3_req_if.sink             req,
   sm3_rsp_if.source           rsp,
   input  sm3_pkg::status_type status,
   input  sm3_pkg::word_type   out_word,
   output sm3_pkg::cmd_type    cmd
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_START,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT,
      ST_REINIT
   } state_type;

   state_type  state_ff, state_in;
   logic       finish_ff, finish_in;   // a finish is in progress
   logic       marked_ff, marked_in;   // 0x80 already written
   logic       final_ff, final_in;     // this block carries the length
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0] rsp_idx_ff, rsp_idx_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       take;

   assign req.ready = (state_ff == ST_IDLE);
   assign take = req.valid && req.ready && (req.mode != MODE_INVALID);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.digest_word = rsp_word_ff;
   assign rsp.word_index = rsp_idx_ff;
   assign rsp.last_word = rsp_last_ff;

   always_comb begin
      cmd = '0;
      cmd.src = SRC_DATA;
      cmd.data = req.data_byte;
      cmd.out_index = idx_ff;
      state_in = state_ff;
      finish_in = finish_ff;
      marked_in = marked_ff;
      final_in = final_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in = rsp_word_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.write_byte = 1'b1;
               finish_in = (req.mode != MODE_ABSORB);
               marked_in = 1'b0;
               final_in = 1'b0;
               if (req.mode == MODE_FINISH) begin
                  // no byte: the 0x80 marker goes in at once
                  cmd.src = SRC_PAD;
                  marked_in = 1'b1;
                  final_in = (status.fill <= 6'd55);
               end else begin
                  cmd.count_len = 1'b1;
               end
               if (status.fill == 6'd63) begin
                  state_in = ST_START;
               end else if (req.mode != MODE_ABSORB) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // 0x80 once, then zeros, length in the last 8 bytes of the final block
            cmd.write_byte = 1'b1;
            if (!marked_ff) begin
               cmd.src = SRC_PAD;
               marked_in = 1'b1;
               final_in = (status.fill <= 6'd55);
            end else if (final_ff && status.fill >= 6'd56) begin
               cmd.src = SRC_LEN;
            end else begin
               cmd.src = SRC_ZERO;
            end
            if (status.fill == 6'd63) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.comp_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.comp_done = 1'b1;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               idx_in = '0;
               state_in = ST_EMIT;
            end else begin
               // extra block: the length goes at its end
               final_in = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = out_word;
               rsp_idx_in = idx_ff;
               rsp_last_in = (idx_ff == 3'd7);
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = ST_REINIT;
               end
            end
         end
         ST_REINIT: begin
            // hold off new bytes until the last word has gone
            cmd.reinit = 1'b1;
            final_in = 1'b0;
            finish_in = 1'b0;
            marked_in = 1'b0;
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         finish_ff <= 1'b0;
         marked_ff <= 1'b0;
         final_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         finish_ff <= finish_in;
         marked_ff <= marked_in;
         final_ff <= final_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end
endmodule

// File: rtl/sm3_hash_engine_unit.sv
// SM3 hash engine, byte serial.
// req channel: one word per message byte; mode 0 absorbs, mode 1 absorbs
// and finishes, mode 2 finishes without a byte, mode 3 is taken and dropped.
// rsp channel: eight digest words per finish, index 0 first, last_word on
// index 7, each word big-endian.
// An absorb writes one byte; every 64th byte adds a compression:
// a start step, 64 rounds (one round per cycle on a single round unit) and
// a fold step. A finish writes the remaining padding one byte a cycle
// (with an extra block when the length no longer fits), each block then
// being compressed, then the emit state loads the first word into the
// output register; words follow one per cycle while the receiver keeps
// ready high.
// req.ready is low while padding, compressing, emitting and until the
// last word has been taken.
// A stalled receiver holds the current word in the output register and
// the engine waits; nothing is lost.
// Reset (synchronous) loads the IV and clears the length and fill count;
// the engine is ready on the next cycle.
module sm3_hash_engine_unit (
   input logic        clock,
   input logic        reset,
   sm3_req_if.sink    req,
   sm3_rsp_if.source  rsp
);
   import sm3_pkg::*;

   cmd_type    cmd;
   status_type status;
   word_type   out_word;

   sm3_control u_ctrl (
      .clock, .reset, .req, .rsp, .status, .out_word, .cmd
   );

   sm3_datapath u_dp (
      .clock, .reset, .cmd, .status, .out_word
   );
endmodule

// File: rtl/sm3_checker.sv
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   // last flag only on the final index
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word mismatch");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("stalled word changed");

   // no new bytes taken while the digest is going out
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("accepting during output");
endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_digest_word(rsp.digest_word), .rsp_word_index(rsp.word_index),
   .rsp_last_word(rsp.last_word)
);
